>>> src/ffa_pkg.sv
// Shared types and constants for the frame first-fit allocator.
// No dependencies.
`default_nettype none

package ffa_pkg;

    localparam int MAX_FRAMES = 64;
    localparam int FRAME_W    = $clog2(MAX_FRAMES);
    localparam int BYTES_W    = 21;
    localparam int SIZE_W     = 17;
    localparam int OWNER_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int PROD_W     = FRAME_W + SIZE_W;
    localparam int END_W      = PROD_W + 1;
    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 72;
    localparam int STATUS_W   = 3;

    localparam logic [BYTES_W-1:0] MEM_BYTES_RST   = 21'd16384;
    localparam logic [SIZE_W-1:0]  FRAME_BYTES_RST = 17'd4096;
    localparam logic [SIZE_W-1:0]  MIN_REQ_RST     = 17'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BYTES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_REQUEST  = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOCATED = 3'd0,
        ST_FREED     = 3'd1,
        ST_REJECTED  = 3'd2,
        ST_NO_SPACE  = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MULT,
        S_COMMIT,
        S_REPORT
    } state_t;

    typedef struct packed {
        logic capture;
        logic decode;
        logic multiply;
        logic commit;
        logic report;
    } dp_cmd_t;

    typedef struct packed {
        logic out_stall;
    } dp_sts_t;

endpackage

`default_nettype wire

>>> src/ffa_ctrl.sv
// Controller state machine for the frame first-fit allocator.
// Depends on ffa_pkg; drives the datapath command struct.
`default_nettype none

module ffa_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire ffa_pkg::dp_sts_t sts,
    output ffa_pkg::dp_cmd_t     cmd
);
    import ffa_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: state_next = S_MULT;
            S_MULT:   state_next = S_COMMIT;
            S_COMMIT: state_next = S_REPORT;
            S_REPORT:
            begin
                if (!sts.out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready     = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            S_DECODE: cmd.decode   = 1'b1;
            S_MULT:   cmd.multiply = 1'b1;
            S_COMMIT: cmd.commit   = 1'b1;
            S_REPORT: cmd.report   = !sts.out_stall;
            default:  cmd          = '0;
        endcase
    end

`ifndef SYNTH
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.decode, cmd.multiply, cmd.commit, cmd.report}))
        else $error("more than one datapath command");

    a_report_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.report |=> (state_reg == S_IDLE))
        else $error("controller did not return to idle after report");
`endif

endmodule

`default_nettype wire

>>> src/ffa_dp.sv
// Datapath: config registers, busy flags, size/owner memories, byte counts, output register.
// Depends on ffa_pkg; sequenced by ffa_ctrl.
`default_nettype none

module ffa_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire ffa_pkg::dp_cmd_t                  cmd,
    output ffa_pkg::dp_sts_t                       sts,
    input  wire logic                              cfg_we,
    input  wire logic [ffa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ffa_pkg::BYTES_W-1:0]       cfg_data,
    input  wire logic [ffa_pkg::S_DATA_W-1:0]      s_tdata,
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [ffa_pkg::M_DATA_W-1:0]           m_tdata,
    output logic [ffa_pkg::STATUS_W-1:0]           m_tuser
);
    import ffa_pkg::*;

    function automatic logic [BYTES_W-1:0] sat_add(input logic [BYTES_W-1:0] a,
                                                   input logic [BYTES_W-1:0] b);
        logic [BYTES_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[BYTES_W] ? {BYTES_W{1'b1}} : s[BYTES_W-1:0];
    endfunction

    function automatic logic [BYTES_W-1:0] sat_sub(input logic [BYTES_W-1:0] a,
                                                   input logic [SIZE_W-1:0]  b);
        logic [BYTES_W-1:0] bx;
        bx = BYTES_W'(b);
        return (bx > a) ? '0 : a - bx;
    endfunction

    // configuration
    logic [BYTES_W-1:0] mem_bytes_reg;
    logic [SIZE_W-1:0]  frame_bytes_reg;
    logic [SIZE_W-1:0]  min_req_reg;

    // captured request
    logic               op_reg;
    logic [OWNER_W-1:0] owner_reg;
    logic [BYTES_W-1:0] size_reg;
    logic [FRAME_W-1:0] idx_reg;

    // state
    logic [MAX_FRAMES-1:0] busy_reg;
    logic [MAX_FRAMES-1:0] busy_next;
    logic [BYTES_W-1:0]    used_reg;
    logic [BYTES_W-1:0]    used_next;
    logic [SIZE_W-1:0]     size_mem  [MAX_FRAMES];
    logic [OWNER_W-1:0]    owner_mem [MAX_FRAMES];

    // intermediate
    logic [FRAME_W-1:0] rd_addr;
    logic [SIZE_W-1:0]  rd_size_reg;
    logic [OWNER_W-1:0] rd_owner_reg;
    logic [FRAME_W-1:0] cand_next;
    logic               any_free_next;
    logic [FRAME_W-1:0] cand_reg;
    logic               any_free_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               reject_reg;
    logic               single_reg;
    logic [END_W-1:0]   end_sum;
    logic               fit;
    logic [BYTES_W-1:0] evict_base;

    // commit decisions
    logic               mem_we;
    logic [FRAME_W-1:0] wr_addr;
    status_t            res_status;
    logic [FRAME_W-1:0] res_grant;
    logic               res_ev;
    logic [OWNER_W-1:0] res_ev_owner;
    status_t            res_status_reg;
    logic [FRAME_W-1:0] res_grant_reg;
    logic               res_ev_reg;
    logic [OWNER_W-1:0] res_ev_owner_reg;

    // output register
    logic               m_tvalid_reg;
    status_t            m_status_reg;
    logic [FRAME_W-1:0] m_grant_reg;
    logic               m_ev_reg;
    logic [OWNER_W-1:0] m_ev_owner_reg;
    logic [BYTES_W-1:0] m_used_reg;
    logic [BYTES_W-1:0] m_free_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_bytes_reg   <= MEM_BYTES_RST;
            frame_bytes_reg <= FRAME_BYTES_RST;
            min_req_reg     <= MIN_REQ_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MEMORY_BYTES: mem_bytes_reg   <= cfg_data;
                CFG_FRAME_BYTES:  frame_bytes_reg <= cfg_data[SIZE_W-1:0];
                CFG_MIN_REQUEST:  min_req_reg     <= cfg_data[SIZE_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= s_tuser;
            owner_reg <= s_tdata[OWNER_W-1:0];
            size_reg  <= s_tdata[OWNER_W +: BYTES_W];
            idx_reg   <= s_tdata[OWNER_W+BYTES_W +: FRAME_W];
        end
    end

    // lowest free frame
    always_comb
    begin
        cand_next     = '0;
        any_free_next = 1'b0;
        for (int k = MAX_FRAMES - 1; k >= 0; k--)
        begin
            if (!busy_reg[k])
            begin
                cand_next     = FRAME_W'(k);
                any_free_next = 1'b1;
            end
        end
    end

    assign rd_addr = (op_reg == OP_FREE) ? idx_reg : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.decode)
        begin
            rd_size_reg  <= size_mem[rd_addr];
            cand_reg     <= cand_next;
            any_free_reg <= any_free_next;
        end
        if (mem_we)
        begin
            size_mem[wr_addr] <= size_reg[SIZE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decode)
        begin
            rd_owner_reg <= owner_mem[rd_addr];
        end
        if (mem_we)
        begin
            owner_mem[wr_addr] <= owner_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.multiply)
        begin
            prod_reg   <= PROD_W'(cand_reg) * PROD_W'(frame_bytes_reg);
            reject_reg <= (size_reg > BYTES_W'(frame_bytes_reg))
                       || (size_reg < BYTES_W'(min_req_reg));
            single_reg <= (mem_bytes_reg == BYTES_W'(frame_bytes_reg));
        end
    end

    assign end_sum    = END_W'(prod_reg) + END_W'(size_reg);
    assign fit        = any_free_reg && (end_sum <= END_W'(mem_bytes_reg));
    assign evict_base = busy_reg[0] ? sat_sub(used_reg, rd_size_reg) : used_reg;

    always_comb
    begin
        busy_next    = busy_reg;
        used_next    = used_reg;
        mem_we       = 1'b0;
        wr_addr      = cand_reg;
        res_status   = ST_NO_SPACE;
        res_grant    = '0;
        res_ev       = 1'b0;
        res_ev_owner = '0;
        if (op_reg == OP_FREE)
        begin
            if (busy_reg[idx_reg])
            begin
                busy_next[idx_reg] = 1'b0;
                used_next          = sat_sub(used_reg, rd_size_reg);
                res_status         = ST_FREED;
                res_grant          = idx_reg;
            end
            else
            begin
                res_status = ST_EMPTY;
            end
        end
        else if (reject_reg)
        begin
            res_status = ST_REJECTED;
        end
        else if (single_reg)
        begin
            res_ev       = busy_reg[0];
            res_ev_owner = busy_reg[0] ? rd_owner_reg : '0;
            busy_next[0] = 1'b1;
            used_next    = sat_add(evict_base, size_reg);
            mem_we       = cmd.commit;
            wr_addr      = '0;
            res_status   = ST_ALLOCATED;
        end
        else if (fit)
        begin
            busy_next[cand_reg] = 1'b1;
            used_next           = sat_add(used_reg, size_reg);
            mem_we              = cmd.commit;
            res_status          = ST_ALLOCATED;
            res_grant           = cand_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
            used_reg <= '0;
        end
        else if (cmd.commit)
        begin
            busy_reg <= busy_next;
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            res_status_reg   <= res_status;
            res_grant_reg    <= res_grant;
            res_ev_reg       <= res_ev;
            res_ev_owner_reg <= res_ev_owner;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.report)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.report)
        begin
            m_status_reg   <= res_status_reg;
            m_grant_reg    <= res_grant_reg;
            m_ev_reg       <= res_ev_reg;
            m_ev_owner_reg <= res_ev_owner_reg;
            m_used_reg     <= used_reg;
            m_free_reg     <= (used_reg > mem_bytes_reg) ? '0 : mem_bytes_reg - used_reg;
        end
    end

    assign sts.out_stall = m_tvalid_reg && !m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign m_tuser       = m_status_reg;
    assign m_tdata       = {{(M_DATA_W - 2*BYTES_W - OWNER_W - 1 - FRAME_W){1'b0}},
                            m_free_reg, m_used_reg, m_ev_owner_reg, m_ev_reg, m_grant_reg};

`ifndef SYNTH
    a_alloc_marks_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && res_status == ST_ALLOCATED) |=> busy_reg[res_grant_reg])
        else $error("granted frame not marked busy");

    a_free_clears_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && res_status == ST_FREED) |=> !busy_reg[res_grant_reg])
        else $error("freed frame still busy");
`endif

endmodule

`default_nettype wire

>>> src/frame_first_fit_allocator.sv
// Top level of the frame first-fit allocator.
// Depends on ffa_pkg, ffa_ctrl and ffa_dp.
`default_nettype none

// Takes one request at a time: a transfer is accepted in idle, then decode (busy-flag
// priority encoder and size/owner memory read), multiply (candidate frame times frame
// size), commit and report. The result becomes valid as ready returns in idle, so a
// new transfer is taken only after the last one is reported; report holds while the
// output register waits on m_tready. The lowest free frame is the only candidate
// checked against the memory bound. Sizes and owners sit in 64-entry memories with one
// read port; no clearing pass after reset.
module frame_first_fit_allocator (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [ffa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ffa_pkg::BYTES_W-1:0]   cfg_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // owner_id[15:0], request_bytes[36:16], frame_index[42:37], zero fill
    input  wire logic [ffa_pkg::S_DATA_W-1:0]  s_tdata,
    // op
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // granted_frame[5:0], evicted_valid[6], evicted_owner[22:7],
    // used_bytes[43:23], free_bytes[64:44], zero fill
    output logic [ffa_pkg::M_DATA_W-1:0]       m_tdata,
    // status
    output logic [ffa_pkg::STATUS_W-1:0]       m_tuser
);
    import ffa_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    ffa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ffa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire
